// ===== rtl/bma_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bma_pkg;

  // Sequencer state codes
  localparam int unsigned StateBits = 2;
  localparam logic [StateBits-1:0] ST_IDLE = 2'd0;  // waiting for an input transfer
  localparam logic [StateBits-1:0] ST_UPD  = 2'd1;  // ring data back, update sum and pointers
  localparam logic [StateBits-1:0] ST_DIV  = 2'd2;  // one quotient bit per cycle
  localparam logic [StateBits-1:0] ST_DONE = 2'd3;  // sign, saturate, load output register

  // Extra running-sum headroom beyond one full window of full-scale samples,
  // covering drift when the window length is changed inside a vector.
  localparam int unsigned GuardBits = 8;

  // Window length after reset
  localparam int unsigned LenReset = 1;

endpackage

`default_nettype wire

// ===== rtl/bma_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface bma_in_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          first;
  logic                          last;

  modport source (output valid, output sample, output first, output last, input ready);
  modport sink   (input valid, input sample, input first, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/bma_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface bma_out_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] average;
  logic                          last_out;

  modport source (output valid, output average, output last_out, input ready);
  modport sink   (input valid, input average, input last_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/bma_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface bma_cfg_if #(
  parameter int LEN_BITS = 9
) ();
  logic                valid;
  logic                ready;
  logic [LEN_BITS-1:0] window_len;

  modport source (output valid, output window_len, input ready);
  modport sink   (input valid, input window_len, output ready);
endinterface

`default_nettype wire

// ===== rtl/boxcar_moving_average_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Boxcar moving average over a stream of signed samples.
// Channels: in_i carries sample/first/last, out_o carries average/last_out,
// cfg_i writes window_len (always ready; write only while the block is idle).
// A transfer on any channel happens when valid and ready are both high.
// first restarts the window; a result is produced only once window_len
// samples of the current vector have arrived, otherwise the sample (and its
// last flag) yields nothing.
// An input that yields a result passes through a ring read, a sum update and
// write-back, the bit-serial divider, and a final step that saturates and
// loads the output register. An input that yields nothing passes through the
// read and the update only. A new input is taken once the previous one has
// been loaded into the output register or has yielded nothing, even while
// its result still waits on out_o.
// When out_o is stalled the block holds the finished result and parks the
// next one in the final stage until the output register frees up.
// Reset clears the sum, fill count, write pointer and output valid and sets
// window_len to 1; the ring memory is not cleared and needs no sweep.
module boxcar_moving_average_core #(
  parameter int WINDOW_MAX  = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  wire    clk_i,
  input  wire    rst_ni,
  bma_in_if.sink   in_i,
  bma_out_if.source out_o,
  bma_cfg_if.sink  cfg_i
);
  import bma_pkg::*;

  localparam int AW       = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int LEN_BITS = $clog2(WINDOW_MAX + 1);
  localparam int LB1      = LEN_BITS + 1;
  localparam int SUM_BITS = SAMPLE_BITS + AW + GuardBits;
  localparam int CNT_BITS = $clog2(SUM_BITS);

  localparam logic [SUM_BITS-1:0] POS_LIM =
    {{(SUM_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};

  // Control and state registers
  logic [StateBits-1:0]           state_q, state_d;
  logic [LEN_BITS-1:0]            len_q;
  logic [AW-1:0]                  wp_q;
  logic [LEN_BITS-1:0]            fill_q;
  logic signed [SUM_BITS-1:0]     sum_q;
  logic                           sub_q;
  logic [CNT_BITS-1:0]            cnt_q;
  logic                           out_valid_q;

  // Payload registers
  logic signed [SAMPLE_BITS-1:0]  smp_q;
  logic                           last_q;
  logic                           neg_q;
  logic [SUM_BITS-1:0]            dvd_q;
  logic [LEN_BITS-1:0]            rem_q;
  logic signed [SAMPLE_BITS-1:0]  avg_q;
  logic                           last_out_q;

  // Ring memory
  logic [SAMPLE_BITS-1:0]         ring_mem [WINDOW_MAX];
  logic [SAMPLE_BITS-1:0]         rd_q;
  logic [AW-1:0]                  rd_addr;

  logic                           in_xfer, out_xfer, cfg_xfer;
  logic [LEN_BITS-1:0]            len_eff;
  logic [AW-1:0]                  wp_eff;
  logic [LEN_BITS-1:0]            fill_eff;
  logic [LB1-1:0]                 old_tmp;
  logic [LEN_BITS-1:0]            fill_new;
  logic signed [SUM_BITS-1:0]     sum_new;
  logic [LB1-1:0]                 trial;
  logic                           trial_ok;
  logic signed [SAMPLE_BITS-1:0]  avg_sat;
  logic                           load_out;

  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_xfer = out_o.valid && out_o.ready;
  assign cfg_xfer = cfg_i.valid && cfg_i.ready;

  assign in_i.ready     = (state_q == ST_IDLE);
  assign cfg_i.ready    = 1'b1;
  assign out_o.valid    = out_valid_q;
  assign out_o.average  = avg_q;
  assign out_o.last_out = last_out_q;

  // Effective window length: zero means one, above the store depth clamps
  always_comb begin
    if (len_q == '0) begin
      len_eff = LEN_BITS'(1);
    end else if (len_q > LEN_BITS'(WINDOW_MAX)) begin
      len_eff = LEN_BITS'(WINDOW_MAX);
    end else begin
      len_eff = len_q;
    end
  end

  // Pointer and count as seen by the accepted sample (first restarts them)
  assign wp_eff   = in_i.first ? '0 : wp_q;
  assign fill_eff = in_i.first ? '0 : fill_q;

  // Address of the sample leaving the window, modulo the store depth
  always_comb begin
    old_tmp = LB1'(wp_eff) - LB1'(len_eff);
    if (LB1'(wp_eff) < LB1'(len_eff)) begin
      old_tmp = old_tmp + LB1'(WINDOW_MAX);
    end
    rd_addr = old_tmp[AW-1:0];
  end

  // Sum and fill update once ring data is back
  assign fill_new = (fill_q < LEN_BITS'(WINDOW_MAX)) ? fill_q + LEN_BITS'(1) : fill_q;
  always_comb begin
    sum_new = sum_q + SUM_BITS'(smp_q);
    if (sub_q) begin
      sum_new = sum_new - SUM_BITS'(signed'(rd_q));
    end
  end

  // Restoring divider step
  assign trial    = {rem_q, dvd_q[SUM_BITS-1]};
  assign trial_ok = (trial >= LB1'(len_eff));

  // Apply sign and saturate to the sample range
  always_comb begin
    if (neg_q) begin
      if (dvd_q > POS_LIM + SUM_BITS'(1)) begin
        avg_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
        avg_sat = -signed'(dvd_q[SAMPLE_BITS-1:0]);
      end
    end else begin
      if (dvd_q > POS_LIM) begin
        avg_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end else begin
        avg_sat = signed'(dvd_q[SAMPLE_BITS-1:0]);
      end
    end
  end

  assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) state_d = ST_UPD;
      end
      ST_UPD: begin
        state_d = (fill_new >= len_eff) ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        if (cnt_q == '0) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (load_out) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Ring memory: read at input transfer, write back in the following cycle (ST_UPD)
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      rd_q <= ring_mem[rd_addr];
    end
    if (state_q == ST_UPD) begin
      ring_mem[wp_q] <= smp_q;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= LEN_BITS'(LenReset);
      wp_q        <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      sub_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_xfer) begin
        len_q <= cfg_i.window_len;
      end
      if (in_xfer) begin
        wp_q   <= wp_eff;
        fill_q <= fill_eff;
        sub_q  <= (fill_eff >= len_eff);
        if (in_i.first) sum_q <= '0;
      end
      if (state_q == ST_UPD) begin
        sum_q  <= sum_new;
        fill_q <= fill_new;
        wp_q   <= (wp_q == AW'(WINDOW_MAX - 1)) ? '0 : wp_q + AW'(1);
        cnt_q  <= CNT_BITS'(SUM_BITS - 1);
      end else if (state_q == ST_DIV) begin
        cnt_q <= cnt_q - CNT_BITS'(1);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      smp_q  <= in_i.sample;
      last_q <= in_i.last;
    end
    if (state_q == ST_UPD) begin
      neg_q <= sum_new[SUM_BITS-1];
      dvd_q <= sum_new[SUM_BITS-1] ? unsigned'(-sum_new) : unsigned'(sum_new);
      rem_q <= '0;
    end else if (state_q == ST_DIV) begin
      dvd_q <= {dvd_q[SUM_BITS-2:0], trial_ok};
      rem_q <= trial_ok ? LEN_BITS'(trial - LB1'(len_eff)) : trial[LEN_BITS-1:0];
    end
    if (load_out) begin
      avg_q      <= avg_sat;
      last_out_q <= last_q;
    end
  end

`ifndef SYNTHESIS
  a_in_to_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == ST_UPD))
    else $error("input transfer did not start a sum update");

  a_div_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) && (cnt_q == '0) |=> (state_q == ST_DONE))
    else $error("divider did not finish after its last step");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= LEN_BITS'(WINDOW_MAX))
    else $error("fill count beyond store depth");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> $stable(avg_q) && $stable(last_out_q))
    else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_boxcar_moving_average_core.sv =====
`timescale 1ns / 1ps

module tb_boxcar_moving_average_core;

  localparam int WinMax       = 256;
  localparam int SettleCycles = 48;    // one item through the divider plus margin
  localparam int HoldCycles   = 400;   // long receiver stall for back-pressure
  localparam int QuietLimit   = 5000;  // cycles with no transfer before giving up
  localparam int RandItems    = 440;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               first;
    logic               last;
  } sample_item_t;

  typedef struct packed {
    logic signed [15:0] average;
    logic               last_out;
  } avg_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bma_in_if  #(.SAMPLE_BITS(16)) in_bus ();
  bma_out_if #(.SAMPLE_BITS(16)) out_bus ();
  bma_cfg_if #(.LEN_BITS(9))     cfg_bus ();

  boxcar_moving_average_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Samples waiting to be offered, and averages waiting to come out
  sample_item_t pending_q[$];
  avg_result_t  avg_expect_q[$];

  // Predictor state
  logic signed [15:0] ring_mem [WinMax];
  logic [7:0]         wr_ptr   = '0;
  int unsigned        fill_cnt = 0;
  longint             acc_sum  = 0;
  logic [8:0]         win_len  = 9'(bma_pkg::LenReset);

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_left   = 0;
  logic hold_req  = 1'b0;
  logic hold_used = 1'b0;

  int mismatch_cnt = 0;
  int in_cnt       = 0;
  int res_cnt      = 0;
  int cfg_cnt      = 0;
  int queued_cnt   = 0;
  int quiet_cnt    = 0;

  sample_item_t next_item;
  sample_item_t took_item;
  avg_result_t  pred_res;
  avg_result_t  want_res;

  // Advance the window by one sample; returns 1 when an average is due
  function automatic bit average_step(input sample_item_t it, output avg_result_t res);
    int unsigned len;
    int          old_idx;
    longint      quot;
    len = (win_len == 0) ? 1 : ((win_len > WinMax) ? WinMax : int'(win_len));
    res = '0;
    if (it.first) begin
      acc_sum  = 0;
      fill_cnt = 0;
      wr_ptr   = '0;
    end
    // drop the sample leaving the window
    if (fill_cnt >= len) begin
      old_idx = (int'(wr_ptr) + WinMax - int'(len)) % WinMax;
      acc_sum -= longint'(ring_mem[old_idx]);
    end
    acc_sum += longint'($signed(it.sample));
    ring_mem[wr_ptr] = it.sample;
    wr_ptr = wr_ptr + 8'd1;
    if (fill_cnt < WinMax) fill_cnt++;
    if (fill_cnt < len) return 1'b0;
    // SV division truncates toward zero; clamp to 16-bit signed
    quot = acc_sum / longint'(len);
    if (quot > 32767) quot = 32767;
    if (quot < -32768) quot = -32768;
    res.average  = 16'(quot);
    res.last_out = it.last;
    return 1'b1;
  endfunction

  function automatic logic signed [15:0] rand_sample();
    int unsigned pick;
    pick = $urandom_range(99, 0);
    case (pick)
      0, 1:    return 16'sh7FFF;
      2, 3:    return 16'sh8000;
      4:       return 16'sh0000;
      5:       return 16'shFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic report_bad(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%s", msg);
  endtask

  // Input driver: offers queued samples and predicts on each transfer
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        in_cnt++;
        took_item.sample = in_bus.sample;
        took_item.first  = in_bus.first;
        took_item.last   = in_bus.last;
        if (average_step(took_item, pred_res)) avg_expect_q.push_back(pred_res);
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (pending_q.size() != 0 && $urandom_range(99, 0) >= tx_idle_pct) begin
          next_item = pending_q.pop_front();
          in_bus.valid  <= 1'b1;
          in_bus.sample <= next_item.sample;
          in_bus.first  <= next_item.first;
          in_bus.last   <= next_item.last;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each result transfer and drives ready
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        res_cnt++;
        if (avg_expect_q.size() == 0) begin
          report_bad($sformatf("unexpected average %0d last=%0b",
                               out_bus.average, out_bus.last_out));
        end else begin
          want_res = avg_expect_q.pop_front();
          if (out_bus.average !== want_res.average || out_bus.last_out !== want_res.last_out)
            report_bad($sformatf("result %0d: expected avg=%0d last=%0b, got avg=%0d last=%0b",
                                 res_cnt, want_res.average, want_res.last_out,
                                 out_bus.average, out_bus.last_out));
        end
      end
      out_bus.ready <= (hold_left == 0) && ($urandom_range(99, 0) >= rx_idle_pct);
    end
  end

  // One long receiver stall, requested once by the stimulus
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_used) begin
      hold_left <= HoldCycles;
      hold_used <= 1'b1;
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt >= QuietLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  task automatic put(input logic signed [15:0] s, input logic f, input logic l);
    sample_item_t it;
    it.sample = s;
    it.first  = f;
    it.last   = l;
    pending_q.push_back(it);
    queued_cnt++;
  endtask

  // Random vector: first/last at the ends by chance, stray flags inside
  task automatic push_vector(input int n, input int first_pct, input int last_pct,
                             input int noise_pct);
    logic f;
    logic l;
    for (int i = 0; i < n; i++) begin
      f = (i == 0) ? ($urandom_range(99, 0) < first_pct) : ($urandom_range(99, 0) < noise_pct);
      l = (i == n - 1) ? ($urandom_range(99, 0) < last_pct)
                       : ($urandom_range(99, 0) < 3 * noise_pct);
      put(rand_sample(), f, l);
    end
  endtask

  // Wait until every sample is taken and every average has come out
  task automatic drain_block();
    do @(posedge clk_i);
    while (pending_q.size() != 0 || in_bus.valid || avg_expect_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Window length write; caller sits right after a rising edge
  task automatic set_window(input logic [8:0] len);
    cfg_bus.valid      <= 1'b1;
    cfg_bus.window_len <= len;
    do @(posedge clk_i);
    while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    win_len = len;
    cfg_cnt++;
  endtask

  initial begin : stimulus
    int eff_len;
    int n_vec;
    int vec_len;
    int pick;
    int rand_base;
    bit big_done;
    bit press_done;

    big_done   = 1'b0;
    press_done = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.sample      = '0;
    in_bus.first       = 1'b0;
    in_bus.last        = 1'b0;
    out_bus.ready      = 1'b0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.window_len = '0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: window of one, field extremes, last on and off
    put(16'sh8000, 1'b1, 1'b1);
    put(16'sh7FFF, 1'b0, 1'b0);
    put(16'sh0000, 1'b0, 1'b0);
    put(-16'sd1,   1'b0, 1'b1);
    put(16'sd1,    1'b0, 1'b0);
    drain_block();
    // zero length acts as one
    set_window(9'd0);
    put(16'sd12345, 1'b1, 1'b0);
    put(-16'sd2,    1'b0, 1'b1);
    drain_block();
    // window not full drops last; negative sums truncate toward zero
    set_window(9'd3);
    put(-16'sd1, 1'b1, 1'b0);
    put(-16'sd1, 1'b0, 1'b1);
    put(16'sd0,  1'b0, 1'b0);
    put(16'sd5,  1'b0, 1'b0);
    put(-16'sd7, 1'b0, 1'b1);
    put(-16'sd9, 1'b0, 1'b0);
    drain_block();
    // length beyond the maximum acts as the maximum
    set_window(9'd511);
    put(16'sd100, 1'b1, 1'b0);
    put(16'sd200, 1'b0, 1'b1);
    drain_block();
    // shrink the window inside a vector: positive then negative saturation
    set_window(9'd2);
    put(16'sh7FFF, 1'b1, 1'b0);
    put(16'sh7FFF, 1'b0, 1'b0);
    drain_block();
    set_window(9'd1);
    put(16'sh7FFF, 1'b0, 1'b1);
    drain_block();
    set_window(9'd2);
    put(16'sh8000, 1'b1, 1'b0);
    put(16'sh8000, 1'b0, 1'b0);
    drain_block();
    set_window(9'd1);
    put(16'sh8000, 1'b0, 1'b0);
    drain_block();
    // grow the window inside a vector
    set_window(9'd4);
    put(16'sd10, 1'b0, 1'b1);
    drain_block();

    // Random phases, three idling regimes in turn
    rand_base = queued_cnt;
    while (queued_cnt - rand_base < RandItems) begin
      if (queued_cnt - rand_base < 80) begin
        tx_idle_pct <= 20;
        rx_idle_pct <= 83;
      end else if (queued_cnt - rand_base < 160) begin
        tx_idle_pct <= 83;
        rx_idle_pct <= 20;
      end else begin
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
      end

      if (!press_done && queued_cnt - rand_base >= 160) begin
        // long receiver stall while samples keep coming
        set_window(9'd3);
        hold_req <= 1'b1;
        push_vector(40, 100, 100, 0);
        press_done = 1'b1;
      end else if (!big_done && queued_cnt - rand_base >= 180) begin
        // full-size window, pointer wraps past the end of the ring
        set_window(9'd256);
        push_vector(270, 100, 100, 0);
        big_done = 1'b1;
      end else begin
        pick = $urandom_range(99, 0);
        if (pick < 5)       set_window(9'd0);
        else if (pick < 12) set_window(9'd1);
        else if (pick < 75) set_window(9'($urandom_range(12, 2)));
        else                set_window(9'($urandom_range(48, 13)));
        eff_len = (win_len == 0) ? 1 : int'(win_len);
        n_vec = $urandom_range(4, 2);
        for (int v = 0; v < n_vec; v++) begin
          if ($urandom_range(99, 0) < 80) vec_len = eff_len + $urandom_range(12, 0);
          else                            vec_len = $urandom_range(eff_len, 1);
          push_vector(vec_len, 90, 85, 2);
        end
      end
      drain_block();
    end

    $display("Checked %0d averages from %0d samples over %0d window-length writes,",
             res_cnt, in_cnt, cfg_cnt);
    $display("with sender and receiver stalls, a long output hold-off and saturation.");
    if (mismatch_cnt == 0 && avg_expect_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
